// File: hdl/rsf_pkg.sv
package rsf_pkg;

    typedef enum logic [2:0] {
        MODE_UNDECIDED = 3'd0,
        MODE_LINE      = 3'd1,
        MODE_GET       = 3'd2,
        MODE_POST      = 3'd3,
        MODE_BINARY    = 3'd4
    } mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } rsf_in_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] message_kind;
        logic       keep_byte;
        logic       drop_previous;
        logic       end_of_message;
        logic       header_error;
    } rsf_out_t;

    localparam logic [7:0] CHAR_STX   = 8'h02;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_C = 8'h63;
    localparam logic [3:0] NAME_LEN   = 4'd14;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] get_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = 8'h67;   // g
            2'd1:    r = 8'h65;   // e
            2'd2:    r = 8'h74;   // t
            default: r = 8'h20;   // space
        endcase
        return r;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = 8'h70;   // p
            2'd1:    r = 8'h6F;   // o
            2'd2:    r = 8'h73;   // s
            default: r = 8'h74;   // t
        endcase
        return r;
    endfunction

    // "content-length"
    function automatic logic [7:0] name_char(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'h63;
            4'd1:    r = 8'h6F;
            4'd2:    r = 8'h6E;
            4'd3:    r = 8'h74;
            4'd4:    r = 8'h65;
            4'd5:    r = 8'h6E;
            4'd6:    r = 8'h74;
            4'd7:    r = 8'h2D;
            4'd8:    r = 8'h6C;
            4'd9:    r = 8'h65;
            4'd10:   r = 8'h6E;
            4'd11:   r = 8'h67;
            4'd12:   r = 8'h74;
            4'd13:   r = 8'h68;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/rsf_len_acc.sv
module rsf_len_acc
    import rsf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic [LENGTH_BITS-1:0] acc,
    input  logic [3:0]             digit,
    output logic [LENGTH_BITS-1:0] acc_next
);

    localparam int WIDE = LENGTH_BITS + 4;

    logic [WIDE-1:0] acc_wide;
    logic [WIDE-1:0] sum_wide;

    // acc*10 + digit; anything above the length field saturates
    assign acc_wide = {4'b0000, acc};
    assign sum_wide = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE-4){1'b0}}, digit};
    assign acc_next = (sum_wide[WIDE-1:LENGTH_BITS] != 4'b0000) ? {LENGTH_BITS{1'b1}}
                                                                : sum_wide[LENGTH_BITS-1:0];

endmodule

// File: hdl/rsf_framer.sv
module rsf_framer
    import rsf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  rsf_in_t  item,
    output rsf_out_t result
);

    typedef enum logic [2:0] {
        PH_NAME   = 3'd0,
        PH_COLON  = 3'd1,
        PH_SPACE  = 3'd2,
        PH_DIGITS = 3'd3,
        PH_REST   = 3'd4,
        PH_BODY   = 3'd5,
        PH_FAILED = 3'd6
    } phase_t;

    mode_t                  mode_reg, mode_next;
    logic [1:0]             sniff_reg, sniff_next;
    logic [1:0]             match_reg, match_next;
    logic [1:0]             term_reg, term_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic [3:0]             name_idx_reg, name_idx_next;
    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic                   line_data_reg, line_data_next;

    logic [7:0]             b;
    logic [7:0]             lb;
    logic [7:0]             term_in;
    logic [2:0]             term_res;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic [LENGTH_BITS-1:0] acc_next;
    logic                   lb_digit;
    logic                   lb_space;
    mode_t                  eff_mode;
    logic                   sniff_hold;
    logic [1:0]             match_new;
    phase_t                 ph_scan;
    logic [LENGTH_BITS-1:0] len_scan;

    // {done, next progress} for the CR LF CR LF search
    function automatic logic [2:0] term_step(input logic [1:0] prog, input logic [7:0] c);
        logic [7:0] want;
        logic [2:0] r;
        want = prog[0] ? CHAR_LF : CHAR_CR;
        if (c == want)
        begin
            if (prog == 2'd3)
            begin
                r = {1'b1, 2'd0};
            end
            else
            begin
                r = {1'b0, prog + 2'd1};
            end
        end
        else
        begin
            r = {1'b0, (c == CHAR_CR) ? 2'd1 : 2'd0};
        end
        return r;
    endfunction

    assign b          = item.data_byte;
    assign lb         = to_lower(b);
    assign term_in    = (eff_mode == MODE_POST) ? lb : b;
    assign term_res   = term_step(term_reg, term_in);
    assign remain_dec = remain_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign lb_digit   = (lb >= CHAR_ZERO) && (lb <= CHAR_NINE);
    assign lb_space   = (lb == CHAR_SPACE) || ((lb >= 8'h09) && (lb <= CHAR_CR));

    rsf_len_acc #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_len_acc (
        .acc      (length_reg),
        .digit    (lb[3:0]),
        .acc_next (acc_next)
    );

    // mode sniffing: the deciding byte is handled under its new mode
    always_comb
    begin
        eff_mode   = mode_reg;
        sniff_hold = 1'b0;
        match_new  = match_reg & {lb == post_char(sniff_reg), lb == get_char(sniff_reg)};
        if (mode_reg == MODE_UNDECIDED)
        begin
            if (sniff_reg == 2'd0 && b == CHAR_STX)
            begin
                eff_mode = MODE_BINARY;
            end
            else if (match_new == 2'b00)
            begin
                eff_mode = MODE_LINE;
            end
            else if (sniff_reg == 2'd3)
            begin
                eff_mode = match_new[0] ? MODE_GET : MODE_POST;
            end
            else
            begin
                sniff_hold = 1'b1;
            end
        end
    end

    // POST header scan
    always_comb
    begin
        ph_scan       = phase_reg;
        len_scan      = length_reg;
        name_idx_next = name_idx_reg;
        case (phase_reg)
            PH_NAME:
            begin
                if (name_idx_reg < NAME_LEN && lb == name_char(name_idx_reg))
                begin
                    name_idx_next = name_idx_reg + 4'd1;
                    if (name_idx_reg + 4'd1 == NAME_LEN)
                    begin
                        ph_scan = PH_COLON;
                    end
                end
                else
                begin
                    name_idx_next = (lb == CHAR_LOW_C) ? 4'd1 : 4'd0;
                end
            end
            PH_COLON:
            begin
                if (lb == CHAR_COLON)
                begin
                    ph_scan = PH_SPACE;
                end
            end
            PH_SPACE:
            begin
                if (lb_digit)
                begin
                    len_scan = {{(LENGTH_BITS-4){1'b0}}, lb[3:0]};
                    ph_scan  = PH_DIGITS;
                end
                else if (lb == CHAR_PLUS)
                begin
                    ph_scan = PH_DIGITS;
                end
                else if (!lb_space)
                begin
                    ph_scan = PH_REST;
                end
            end
            PH_DIGITS:
            begin
                if (lb_digit)
                begin
                    len_scan = acc_next;
                end
                else
                begin
                    ph_scan = PH_REST;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        sniff_next     = sniff_reg;
        match_next     = match_reg;
        term_next      = term_reg;
        prev_cr_next   = prev_cr_reg;
        phase_next     = phase_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        line_data_next = line_data_reg;
        result         = '0;
        if (item.kind)
        begin
            mode_next      = MODE_UNDECIDED;
            sniff_next     = 2'd0;
            match_next     = 2'b11;
            term_next      = 2'd0;
            prev_cr_next   = 1'b0;
            phase_next     = PH_NAME;
            length_next    = '0;
            remain_next    = '0;
            line_data_next = 1'b0;
        end
        else
        begin
            if (mode_reg == MODE_UNDECIDED && !(sniff_reg == 2'd0 && b == CHAR_STX))
            begin
                match_next = match_new;
            end
            mode_next = eff_mode;
            if (sniff_hold)
            begin
                sniff_next            = sniff_reg + 2'd1;
                result.byte_out       = b;
                result.message_kind   = MODE_UNDECIDED;
                result.keep_byte      = 1'b1;
            end
            else
            begin
                case (eff_mode)
                    MODE_LINE:
                    begin
                        result.byte_out     = b;
                        result.message_kind = MODE_LINE;
                        if (b == CHAR_LF)
                        begin
                            result.drop_previous  = prev_cr_reg;
                            result.end_of_message = line_data_reg;
                            line_data_next        = 1'b0;
                            prev_cr_next          = 1'b0;
                        end
                        else
                        begin
                            result.keep_byte = 1'b1;
                            line_data_next   = 1'b1;
                            prev_cr_next     = (b == CHAR_CR);
                        end
                    end
                    MODE_GET:
                    begin
                        term_next             = term_res[1:0];
                        result.byte_out       = b;
                        result.message_kind   = MODE_GET;
                        result.keep_byte      = 1'b1;
                        result.end_of_message = term_res[2];
                    end
                    MODE_POST:
                    begin
                        result.message_kind = MODE_POST;
                        if (phase_reg == PH_BODY)
                        begin
                            result.byte_out  = b;
                            result.keep_byte = 1'b1;
                            remain_next      = remain_dec;
                            if (remain_dec == '0)
                            begin
                                result.end_of_message = 1'b1;
                                phase_next            = PH_NAME;
                                term_next             = 2'd0;
                                length_next           = '0;
                                remain_next           = '0;
                            end
                        end
                        else if (phase_reg == PH_FAILED)
                        begin
                            result.byte_out = b;
                        end
                        else
                        begin
                            result.byte_out  = lb;
                            result.keep_byte = 1'b1;
                            term_next        = term_res[1:0];
                            phase_next       = ph_scan;
                            length_next      = len_scan;
                            if (term_res[2])
                            begin
                                if (ph_scan == PH_NAME || ph_scan == PH_COLON)
                                begin
                                    result.header_error = 1'b1;
                                    phase_next          = PH_FAILED;
                                end
                                else if (len_scan == '0)
                                begin
                                    result.end_of_message = 1'b1;
                                    phase_next            = PH_NAME;
                                    length_next           = '0;
                                    remain_next           = '0;
                                end
                                else
                                begin
                                    remain_next = len_scan;
                                    phase_next  = PH_BODY;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        result.byte_out     = b;
                        result.message_kind = MODE_BINARY;
                        result.keep_byte    = 1'b1;
                    end
                endcase
            end
        end
    end

    // name index also clears whenever the POST state clears
    logic [3:0] name_idx_final;
    always_comb
    begin
        name_idx_final = name_idx_reg;
        if (item.kind)
        begin
            name_idx_final = 4'd0;
        end
        else if (!sniff_hold && eff_mode == MODE_POST)
        begin
            if (phase_next == PH_NAME && (phase_reg == PH_BODY || result.end_of_message))
            begin
                name_idx_final = 4'd0;
            end
            else if (phase_reg != PH_BODY && phase_reg != PH_FAILED)
            begin
                name_idx_final = name_idx_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_UNDECIDED;
            sniff_reg     <= 2'd0;
            match_reg     <= 2'b11;
            term_reg      <= 2'd0;
            prev_cr_reg   <= 1'b0;
            name_idx_reg  <= 4'd0;
            phase_reg     <= PH_NAME;
            length_reg    <= '0;
            remain_reg    <= '0;
            line_data_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            sniff_reg     <= sniff_next;
            match_reg     <= match_next;
            term_reg      <= term_next;
            prev_cr_reg   <= prev_cr_next;
            name_idx_reg  <= name_idx_final;
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            remain_reg    <= remain_next;
            line_data_reg <= line_data_next;
        end
    end

endmodule

// File: hdl/request_stream_framer.sv
// channel   dir  handshake                    payload
// item      in   item_valid / item_ready      rsf_in_t  {kind, data_byte}
// result    out  result_valid / result_ready  rsf_out_t {byte_out .. header_error}
//
// One item per cycle sustained while results are taken; each item's result passes
// through the input register, then the result register.
// The framing state updates in the same cycle an item moves into the result register.
// A stalled result holds in the result register while one more item waits in
// the input register; item_ready drops only when both are full.
// Reset clears the framing state and both valid flags; no clearing pass.
module request_stream_framer
    import rsf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  rsf_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output rsf_out_t result
);

    rsf_in_t  item_reg;
    logic     item_valid_reg;
    rsf_out_t result_reg;
    rsf_out_t step_result;
    logic     result_valid_reg;
    logic     advance;

    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    rsf_framer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("result register not filled after advance");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("pending item lost from input register");

    a_header_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.header_error |->
            result_reg.message_kind == MODE_POST && result_reg.keep_byte &&
            !result_reg.end_of_message)
        else $error("header error outside a POST header end");

    a_drop_cr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.drop_previous |->
            result_reg.message_kind == MODE_LINE && !result_reg.keep_byte &&
            result_reg.byte_out == CHAR_LF)
        else $error("carriage return strip outside a line end");

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsf_pkg::*;

    localparam int LEN_BITS     = 32;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [LEN_BITS-1:0] LEN_MAX  = '1;
    localparam logic [8*14-1:0]     CL_NAME  = "content-length";
    localparam logic [8*4-1:0]      GET_PFX  = "get ";
    localparam logic [8*4-1:0]      POST_PFX = "post";
    localparam logic [7:0]          CHAR_TAB = 8'h09;
    localparam logic [7:0]          CHAR_A   = 8'h61;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_COLON,
        PH_SPACE,
        PH_DIGITS,
        PH_REST,
        PH_BODY,
        PH_FAILED
    } post_phase_t;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    rsf_in_t  item;
    logic     result_valid;
    logic     result_ready;
    rsf_out_t result;

    // framing state mirrored from the block
    mode_t               sess_mode;
    logic [2:0]          sniff_cnt;
    logic [1:0]          pfx_live;
    logic [1:0]          crlf_prog;
    logic                prev_cr;
    logic [3:0]          name_idx;
    post_phase_t         post_ph;
    logic [LEN_BITS-1:0] body_len;
    logic [LEN_BITS-1:0] body_left;
    logic                line_nonempty;

    rsf_out_t frames_due[$];

    int send_idle_pct;
    int stall_pct;
    int items_sent;
    int conns_sent;
    int results_checked;
    int mismatches;
    int ends_due;
    int header_errors_due;
    int cycle_count;
    int sessions_by_mode[5];

    request_stream_framer #(
        .LENGTH_BITS (LEN_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // tracks CR LF CR LF, returns 1 on the byte that completes it
    function automatic logic crlf_advance(input logic [7:0] c);
        logic [7:0] want;
        logic       hit;
        want = crlf_prog[0] ? CHAR_LF : CHAR_CR;
        hit  = 1'b0;
        if (c == want)
        begin
            if (crlf_prog == 2'd3)
            begin
                crlf_prog = 2'd0;
                hit       = 1'b1;
            end
            else
            begin
                crlf_prog = crlf_prog + 2'd1;
            end
        end
        else
        begin
            crlf_prog = (c == CHAR_CR) ? 2'd1 : 2'd0;
        end
        return hit;
    endfunction

    function automatic void post_restart();
        post_ph   = PH_NAME;
        name_idx  = '0;
        crlf_prog = '0;
        body_len  = '0;
        body_left = '0;
    endfunction

    function automatic void framer_clear();
        sess_mode     = MODE_UNDECIDED;
        sniff_cnt     = '0;
        pfx_live      = 2'b11;
        prev_cr       = 1'b0;
        line_nonempty = 1'b0;
        post_restart();
    endfunction

    function automatic rsf_out_t frame_byte(input rsf_in_t it);
        rsf_out_t            r;
        logic [7:0]          b;
        logic [7:0]          lb;
        logic [1:0]          idx;
        logic                done;
        logic [LEN_BITS-1:0] d;
        r = '0;
        b = it.data_byte;
        if (it.kind)
        begin
            framer_clear();
            return r;
        end
        r.byte_out  = b;
        r.keep_byte = 1'b1;
        if (sess_mode == MODE_UNDECIDED)
        begin
            lb  = fold_case(b);
            idx = sniff_cnt[1:0];
            if (sniff_cnt == 3'd0 && b == CHAR_STX)
            begin
                sess_mode = MODE_BINARY;
            end
            else
            begin
                if (lb != GET_PFX[8*(3-idx) +: 8])
                    pfx_live[0] = 1'b0;
                if (lb != POST_PFX[8*(3-idx) +: 8])
                    pfx_live[1] = 1'b0;
                if (pfx_live == 2'b00)
                begin
                    sess_mode = MODE_LINE;
                end
                else if (idx == 2'd3)
                begin
                    sess_mode = pfx_live[0] ? MODE_GET : MODE_POST;
                end
                else
                begin
                    sniff_cnt = idx + 3'd1;
                    return r;
                end
            end
            sessions_by_mode[sess_mode]++;
        end
        r.message_kind = sess_mode;
        case (sess_mode)
            MODE_LINE:
            begin
                if (b == CHAR_LF)
                begin
                    r.keep_byte      = 1'b0;
                    r.drop_previous  = prev_cr;
                    r.end_of_message = line_nonempty;
                    line_nonempty    = 1'b0;
                    prev_cr          = 1'b0;
                end
                else
                begin
                    line_nonempty = 1'b1;
                    prev_cr       = (b == CHAR_CR);
                end
            end
            MODE_GET:
            begin
                r.end_of_message = crlf_advance(b);
            end
            MODE_POST:
            begin
                if (post_ph == PH_BODY)
                begin
                    body_left = body_left - 1'b1;
                    if (body_left == '0)
                    begin
                        r.end_of_message = 1'b1;
                        post_restart();
                    end
                end
                else if (post_ph == PH_FAILED)
                begin
                    r.keep_byte = 1'b0;
                end
                else
                begin
                    lb   = fold_case(b);
                    done = crlf_advance(lb);
                    case (post_ph)
                        PH_NAME:
                        begin
                            if (name_idx < NAME_LEN && lb == CL_NAME[8*(13-int'(name_idx)) +: 8])
                            begin
                                name_idx = name_idx + 4'd1;
                                if (name_idx == NAME_LEN)
                                    post_ph = PH_COLON;
                            end
                            else
                            begin
                                name_idx = (lb == CHAR_LOW_C) ? 4'd1 : 4'd0;
                            end
                        end
                        PH_COLON:
                        begin
                            if (lb == CHAR_COLON)
                                post_ph = PH_SPACE;
                        end
                        PH_SPACE:
                        begin
                            if (is_digit(lb))
                            begin
                                body_len = LEN_BITS'(lb - CHAR_ZERO);
                                post_ph  = PH_DIGITS;
                            end
                            else if (lb == CHAR_PLUS)
                            begin
                                post_ph = PH_DIGITS;
                            end
                            else if (!is_blank(lb))
                            begin
                                post_ph = PH_REST;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit(lb))
                            begin
                                d = LEN_BITS'(lb - CHAR_ZERO);
                                // saturate instead of wrapping
                                if (body_len > (LEN_MAX - d) / 10)
                                    body_len = LEN_MAX;
                                else
                                    body_len = body_len * 10 + d;
                            end
                            else
                            begin
                                post_ph = PH_REST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (done)
                    begin
                        if (post_ph < PH_SPACE)
                        begin
                            r.header_error = 1'b1;
                            post_ph        = PH_FAILED;
                        end
                        else if (body_len == '0)
                        begin
                            r.end_of_message = 1'b1;
                            post_restart();
                        end
                        else
                        begin
                            body_left = body_len;
                            post_ph   = PH_BODY;
                        end
                    end
                    r.byte_out = lb;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic field_check(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input rsf_out_t got);
        rsf_out_t want;
        if (frames_due.size() == 0)
        begin
            mismatches++;
            $display("%0t ns: result with nothing due, expected none actual %p", $time, got);
            return;
        end
        want = frames_due.pop_front();
        results_checked++;
        field_check("byte_out", 32'(want.byte_out), 32'(got.byte_out));
        field_check("message_kind", 32'(want.message_kind), 32'(got.message_kind));
        field_check("keep_byte", 32'(want.keep_byte), 32'(got.keep_byte));
        field_check("drop_previous", 32'(want.drop_previous), 32'(got.drop_previous));
        field_check("end_of_message", 32'(want.end_of_message), 32'(got.end_of_message));
        field_check("header_error", 32'(want.header_error), 32'(got.header_error));
    endtask

    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                check_result(result);
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout, %0d results still due", $time, frames_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- item side

    task automatic send_item(input rsf_in_t it);
        rsf_out_t due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        due = frame_byte(it);
        frames_due.push_back(due);
        items_sent++;
        ends_due          += int'(due.end_of_message);
        header_errors_due += int'(due.header_error);
    endtask

    task automatic send_data(input logic [7:0] b);
        rsf_in_t it;
        it.kind      = 1'b0;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic send_conn();
        rsf_in_t it;
        it.kind      = 1'b1;
        it.data_byte = 8'($urandom_range(255));
        conns_sent++;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_data(s[i]);
    endtask

    function automatic string mix_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
        begin
            if (r[i] >= CHAR_A && r[i] <= 8'h7A && $urandom_range(1) == 1)
                r[i] = r[i] - 8'd32;
        end
        return r;
    endfunction

    function automatic string rand_word(input int len);
        string s;
        s = "";
        for (int i = 0; i < len; i++)
            s = $sformatf("%s%c", s, CHAR_A + $urandom_range(25));
        return s;
    endfunction

    function automatic string blank_run();
        string s;
        case ($urandom_range(4))
            0:       s = "";
            1:       s = " ";
            2:       s = "\t";
            3:       s = "  ";
            default: s = " \t ";
        endcase
        return s;
    endfunction

    function automatic string header_line();
        return mix_case($sformatf("x-%s: %s\r\n", rand_word($urandom_range(1, 6)),
                                  rand_word($urandom_range(1, 6))));
    endfunction

    task automatic binary_session();
        send_conn();
        send_data(CHAR_STX);
        repeat ($urandom_range(1, 30))
            send_data(8'($urandom_range(255)));
    endtask

    task automatic line_session();
        logic [7:0] c;
        send_conn();
        repeat ($urandom_range(1, 6))
        begin
            repeat ($urandom_range(0, 8))
            begin
                case ($urandom_range(9))
                    0:       c = CHAR_CR;
                    1, 2:    c = 8'($urandom_range(255));
                    default: c = 8'(CHAR_A + $urandom_range(25));
                endcase
                send_data(c);
            end
            if ($urandom_range(1) == 1)
                send_data(CHAR_CR);
            send_data(CHAR_LF);
        end
    endtask

    task automatic get_session();
        send_conn();
        repeat ($urandom_range(1, 4))
        begin
            send_text(mix_case($sformatf("get /%s http/1.1\r\n", rand_word($urandom_range(1, 6)))));
            repeat ($urandom_range(0, 3))
                send_text(header_line());
            // stray CR restarts the terminator search
            if ($urandom_range(4) == 0)
                send_data(CHAR_CR);
            send_text("\r\n");
        end
    endtask

    // one POST request; dead is set when the session can't carry another one
    task automatic post_request(output bit dead);
        string hdr;
        string cl_line;
        string sign;
        string big;
        int    n;
        dead = 1'b0;
        sign = "";
        if ($urandom_range(3) == 0)
            sign = "+";
        case ($urandom_range(2))
            0:       big = "4294967295";
            1:       big = "4294967296";
            default: big = "99999999999999";
        endcase
        case ($urandom_range(11))
            6:  cl_line = "";
            7:  cl_line = $sformatf("%s %0d\r\n", mix_case("content-length"), $urandom_range(1, 9));
            8:  cl_line = $sformatf("%s: -%0d\r\n", mix_case("content-length"), $urandom_range(1, 9));
            9:  cl_line = $sformatf("content-length:%s%s\r\n", blank_run(), big);
            10: cl_line = $sformatf("conten-length: 9\r\nCcontent-length:%0d;x\r\n",
                                    $urandom_range(0, 24));
            11: cl_line = $sformatf("%s: abc\r\n", mix_case("content-length"));
            default:
                cl_line = $sformatf("%s:%s%s%0d\r\n", mix_case("content-length"), blank_run(),
                                    sign, $urandom_range(0, 24));
        endcase
        hdr = mix_case($sformatf("post /%s http/1.1\r\n", rand_word($urandom_range(1, 6))));
        repeat ($urandom_range(0, 2))
            hdr = {hdr, header_line()};
        hdr = {hdr, cl_line};
        repeat ($urandom_range(0, 1))
            hdr = {hdr, header_line()};
        hdr = {hdr, "\r\n"};
        send_text(hdr);
        if (post_ph == PH_BODY)
        begin
            // huge lengths: send part of the body, the next connection cuts it off
            dead = (body_left > 64);
            n    = dead ? $urandom_range(5, 30) : int'(body_left);
            repeat (n)
                send_data(8'($urandom_range(255)));
        end
        else if (post_ph == PH_FAILED)
        begin
            dead = 1'b1;
            repeat ($urandom_range(1, 6))
                send_data(8'($urandom_range(255)));
        end
    endtask

    task automatic post_session();
        bit dead;
        send_conn();
        for (int i = $urandom_range(1, 4); i > 0; i--)
        begin
            post_request(dead);
            if (dead)
                break;
        end
    endtask

    // partial prefixes, late STX, connection resets mid-stream
    task automatic noise_session();
        if ($urandom_range(3) != 0)
            send_conn();
        case ($urandom_range(6))
            0:       send_text("g");
            1:       send_text("Ge");
            2:       send_text("pO");
            3:       send_text("poS");
            4:       send_text("get");
            5:       send_text("gEt ");
            default: send_data(CHAR_STX);
        endcase
        repeat ($urandom_range(3, 25))
        begin
            if ($urandom_range(29) == 0)
                send_conn();
            else if ($urandom_range(9) == 0)
                send_data(CHAR_STX);
            else
                send_data(8'($urandom_range(255)));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_conn();
        send_data(CHAR_STX);
        send_data(8'hFF);
        send_data(8'h00);
        send_conn();
        send_text("a\r\n");
        send_data(CHAR_LF);
        send_conn();
        send_text("GeT \r\n\r\n");
        send_conn();
        send_text("pOsT\r\n\r\n");
        send_data(8'h41);
    endtask

    task automatic test_line_and_binary(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            if ($urandom_range(2) == 0)
                binary_session();
            else
                line_session();
        end
    endtask

    task automatic test_get_requests(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
            get_session();
    endtask

    task automatic test_post_requests(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
            post_session();
    endtask

    task automatic test_mixed_sessions(input int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            case ($urandom_range(9))
                0:       binary_session();
                1, 2:    line_session();
                3, 4:    get_session();
                5, 6, 7: post_session();
                default: noise_session();
            endcase
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        item          <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        framer_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_line_and_binary(250);
        test_mixed_sessions(100);

        send_idle_pct = 81;
        stall_pct     = 0;
        test_get_requests(350);
        test_mixed_sessions(100);

        send_idle_pct = 0;
        stall_pct     = 81;
        test_post_requests(600);
        test_mixed_sessions(100);

        send_idle_pct = 23;
        stall_pct     = 23;
        test_mixed_sessions(400);

        item_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d connections: %0d line, %0d GET, %0d POST, %0d binary.",
                 items_sent, conns_sent, sessions_by_mode[MODE_LINE], sessions_by_mode[MODE_GET],
                 sessions_by_mode[MODE_POST], sessions_by_mode[MODE_BINARY]);
        $display("Checked %0d results with %0d request ends and %0d header errors, %0d mismatches.",
                 results_checked, ends_due, header_errors_due, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
